### src/lsod_pkg.sv
// ----------------------------------------------------------------------------
// lsod_pkg
// Shared types, constants and helpers for the line splitter with overflow drop.
// ----------------------------------------------------------------------------
package lsod_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int LIMIT_W     = 7;
  localparam int MIN_LIMIT   = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 7;

  localparam logic [7:0] NEWLINE = 8'h0A;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_LIMIT  = 1'b0,
    CFG_FOLLOW_MODE = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    KIND_BYTE     = 3'd0,
    KIND_EMPTY    = 3'd1,
    KIND_OVERFLOW = 3'd2,
    KIND_END      = 3'd3,
    KIND_WAIT     = 3'd4
  } kind_t;

  typedef enum logic {
    ACT_DATA = 1'b0,
    ACT_EOS  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_LD,
    S_END
  } state_t;

  typedef struct packed {
    logic       action;
    logic [7:0] data_in;
  } in_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_out;
    logic       line_end;
    logic       last;
  } out_t;

  // Settings handed from the register block to the sequencer.
  typedef struct packed {
    logic [CNT_W-1:0] limit;
    logic             follow;
  } ctl_cfg_t;

  // Zero selects the full store; other values clamp to [MIN_LIMIT, STORE_DEPTH].
  function automatic logic [CNT_W-1:0] eff_limit(input logic [LIMIT_W-1:0] l);
    logic [CNT_W-1:0] r;
    if (l == '0 || int'(l) > STORE_DEPTH) begin
      r = CNT_W'(STORE_DEPTH);
    end else if (int'(l) < MIN_LIMIT) begin
      r = CNT_W'(MIN_LIMIT);
    end else begin
      r = CNT_W'(l);
    end
    return r;
  endfunction

endpackage

### src/lsod_ram.sv
// ----------------------------------------------------------------------------
// lsod_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lsod_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/lsod_ctrl.sv
// ----------------------------------------------------------------------------
// lsod_ctrl
// Sequencer: takes transactions, writes bytes into the line store, reads a
// finished line back out byte by byte (store read, then output load), owns the output register.
// ----------------------------------------------------------------------------
module lsod_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lsod_pkg::ctl_cfg_t    cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lsod_pkg::in_t         in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lsod_pkg::out_t        out_data,
  output logic                  mem_we,
  output logic [lsod_pkg::ADDR_W-1:0] mem_waddr,
  output logic [7:0]            mem_wdata,
  output logic                  mem_re,
  output logic [lsod_pkg::ADDR_W-1:0] mem_raddr,
  input  logic [7:0]            mem_rdata
);
  import lsod_pkg::*;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  held_r, held_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic              disc_r, disc_nxt;
  logic              ended_r, ended_nxt;
  logic              tail_end_r, tail_end_nxt;
  logic              last_item_r, last_item_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r, out_data_nxt;

  logic              slot_free;
  logic              accept;
  logic              is_nl;
  logic              fin;
  logic [CNT_W-1:0]  held_inc;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;
  assign is_nl     = (in_data.data_in == NEWLINE);
  assign held_inc  = held_r + CNT_W'(1);
  assign fin       = ((CNT_W'(idx_r) + CNT_W'(1)) == held_r);

  // Store write happens only on a data byte that is being held.
  assign mem_we    = accept && !ended_r && (in_data.action == ACT_DATA) && !disc_r && !is_nl;
  assign mem_waddr = held_r[ADDR_W-1:0];
  assign mem_wdata = in_data.data_in;
  assign mem_re    = (state_r == S_RD);
  assign mem_raddr = idx_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && !ended_r && is_nl && (in_data.action == ACT_DATA) && !disc_r &&
            held_r != '0) begin
          state_nxt = S_RD;
        end else if (accept && !ended_r && (in_data.action == ACT_EOS) && !cfg.follow &&
                     !disc_r && held_r != '0) begin
          state_nxt = S_RD;
        end
      end
      S_RD: state_nxt = S_LD;
      S_LD: begin
        if (slot_free) begin
          if (!fin)           state_nxt = S_RD;
          else if (tail_end_r) state_nxt = S_END;
          else                state_nxt = S_IDLE;
        end
      end
      S_END: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    held_nxt      = held_r;
    idx_nxt       = idx_r;
    disc_nxt      = disc_r;
    ended_nxt     = ended_r;
    tail_end_nxt  = tail_end_r;
    last_item_nxt = last_item_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (ended_r) begin
            if (in_data.action == ACT_EOS) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{kind: KIND_END, data_out: '0, line_end: 1'b0, last: 1'b1};
            end
          end else if (in_data.action == ACT_DATA) begin
            if (disc_r) begin
              if (is_nl) disc_nxt = 1'b0;
            end else if (is_nl) begin
              if (held_r == '0) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{kind: KIND_EMPTY, data_out: '0, line_end: 1'b1, last: 1'b1};
              end else begin
                idx_nxt       = '0;
                last_item_nxt = 1'b1;
                tail_end_nxt  = 1'b0;
              end
            end else if (held_inc >= cfg.limit) begin
              held_nxt      = '0;
              disc_nxt      = 1'b1;
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{kind: KIND_OVERFLOW, data_out: '0, line_end: 1'b0, last: 1'b1};
            end else begin
              held_nxt = held_inc;
            end
          end else if (cfg.follow) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{kind: KIND_WAIT, data_out: '0, line_end: 1'b0, last: 1'b1};
          end else begin
            ended_nxt = 1'b1;
            if (disc_r || held_r == '0) begin
              disc_nxt      = 1'b0;
              held_nxt      = '0;
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{kind: KIND_END, data_out: '0, line_end: 1'b0, last: 1'b1};
            end else begin
              idx_nxt       = '0;
              last_item_nxt = 1'b0;
              tail_end_nxt  = 1'b1;
            end
          end
        end
      end
      S_RD: ;
      S_LD: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{kind: KIND_BYTE, data_out: mem_rdata, line_end: fin,
                            last: fin && last_item_r};
          if (fin) held_nxt = '0;
          else     idx_nxt  = idx_r + ADDR_W'(1);
        end
      end
      S_END: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{kind: KIND_END, data_out: '0, line_end: 1'b0, last: 1'b1};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= '0;
      disc_r      <= 1'b0;
      ended_r     <= 1'b0;
      tail_end_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      disc_r      <= disc_nxt;
      ended_r     <= ended_nxt;
      tail_end_r  <= tail_end_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    last_item_r <= last_item_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### src/line_splitter_with_overflow_drop.sv
// ----------------------------------------------------------------------------
// line_splitter_with_overflow_drop
// Newline-delimited line framer: holds bytes in a line store, emits a whole
// line on newline (or on end of stream with follow mode off), reports overflow and drops over-long lines.
// ----------------------------------------------------------------------------
//  channel | signals                        | transaction moves
//  --------+--------------------------------+-------------------------------
//  in      | in_valid/in_ready, in_data     | one stream byte or end of stream
//  out     | out_valid/out_ready, out_data  | one line byte or status result
//  cfg     | cfg_we, cfg_index, cfg_wdata   | one register write, no wait
//
//  A byte that is held is written into the store. A completed line is read
//  back byte by byte (store read, then load into the output register, which
//  waits while the output register is stalled); the sequencer waits for each
//  store read before it issues the next. Status results go straight into the
//  output register.
//  Reset (rst_n low, synchronous) empties the held line, clears the discard
//  and ended states and restores line_limit 64, follow_mode 0. The store is
//  not cleared: only entries written for the current line are read.
//  A stalled out_ready holds the output register; input is taken only while
//  the sequencer is idle and the output register is free or being drained.
// ----------------------------------------------------------------------------
module line_splitter_with_overflow_drop (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  lsod_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output lsod_pkg::out_t                   out_data,
  input  logic                             cfg_we,
  input  logic [lsod_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lsod_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import lsod_pkg::*;

  // Configuration registers
  logic [LIMIT_W-1:0] line_limit_r;
  logic               follow_mode_r;
  ctl_cfg_t           ctl_cfg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_limit_r  <= LIMIT_W'(64);
      follow_mode_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_LINE_LIMIT:  line_limit_r  <= cfg_wdata[LIMIT_W-1:0];
        CFG_FOLLOW_MODE: follow_mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Clamp once here; the sequencer only ever sees a legal limit.
  assign ctl_cfg.limit  = eff_limit(line_limit_r);
  assign ctl_cfg.follow = follow_mode_r;

  // Line store port signals
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [7:0]        mem_rdata;

  lsod_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (ctl_cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Writes happen only while idle and reads only while draining a line,
  // so the two ports never touch the same entry in one cycle.
  lsod_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

### src/lsod_checker.sv
// ----------------------------------------------------------------------------
// lsod_checker
// Port-level checks for the line splitter, attached by bind.
// ----------------------------------------------------------------------------
module lsod_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input lsod_pkg::out_t out_data
);
  import lsod_pkg::*;

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // No result is pending right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> !out_valid)
    else $error("result valid after reset");

  // Once an end marker has gone out, only end markers follow.
  a_ended_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.kind == KIND_END |=>
      !(out_valid && out_data.kind != KIND_END))
    else $error("result other than end after end");

  // Empty, overflow and waiting results are direct answers to a transaction.
  a_status_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(rst_n) && $past(!out_valid || out_ready) &&
    (out_data.kind == KIND_EMPTY || out_data.kind == KIND_OVERFLOW ||
     out_data.kind == KIND_WAIT) |-> $past(in_valid && in_ready))
    else $error("status result without input transaction");

endmodule

bind line_splitter_with_overflow_drop lsod_checker u_lsod_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
